// File: sv/cdiv_pkg.sv
// shared types, constants and the division step for the complex divider
// no dependencies
package cdiv_pkg;

  localparam int InW   = 16;
  localparam int OutW  = 24;
  localparam int QuoW  = 25;
  localparam int NumW  = 45;
  localparam int DvsW  = 33;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DvsW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    lane_t           re;
    lane_t           im;
    logic [DvsW-1:0] dvs;
    logic            zero;
  } div_item_t;

  typedef struct packed {
    logic [NumW-1:0] n_re;
    logic [NumW-1:0] n_im;
    logic            neg_re;
    logic            neg_im;
    logic [DvsW-1:0] dvs;
    logic            zero;
  } front_t;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic lane_t div_step(lane_t l, logic [DvsW-1:0] dvs);
    logic [DvsW:0] t;
    logic          ge;
    lane_t         r;
    t       = {l.rem, l.low[QuoW-1]};
    ge      = t >= {1'b0, dvs};
    r       = l;
    r.rem   = ge ? DvsW'(t - {1'b0, dvs}) : t[DvsW-1:0];
    r.low   = {l.low[QuoW-2:0], 1'b0};
    r.quo   = {l.quo[QuoW-2:0], ge};
    return r;
  endfunction

  // first division stage: top numerator bits form the remainder, overflow check
  function automatic lane_t div_init(logic [NumW-1:0] n, logic neg, logic [DvsW-1:0] dvs);
    lane_t r;
    r.rem = DvsW'(n[NumW-1:QuoW]);
    r.low = n[QuoW-1:0];
    r.quo = '0;
    r.neg = neg;
    r.ovf = DvsW'(n[NumW-1:QuoW]) >= dvs;
    return r;
  endfunction

endpackage

// File: sv/cdiv_if.sv
// valid/ready channel interfaces for operands and quotients
// depends on cdiv_pkg
interface cdiv_req_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cdiv_pkg::InW-1:0]      dividend_re;
  logic signed [cdiv_pkg::InW-1:0]      dividend_im;
  logic signed [cdiv_pkg::InW-1:0]      divisor_re;
  logic signed [cdiv_pkg::InW-1:0]      divisor_im;
  modport source (output valid, dividend_re, dividend_im, divisor_re, divisor_im,
                  input ready);
  modport sink   (input valid, dividend_re, dividend_im, divisor_re, divisor_im,
                  output ready);
endinterface

interface cdiv_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cdiv_pkg::OutW-1:0]     quotient_re;
  logic signed [cdiv_pkg::OutW-1:0]     quotient_im;
  logic        [1:0]                    status;
  modport source (output valid, quotient_re, quotient_im, status, input ready);
  modport sink   (input valid, quotient_re, quotient_im, status, output ready);
endinterface

// File: sv/cdiv_front.sv
// products, numerators, denominator, magnitudes and scaled dividends
// depends on cdiv_pkg
module cdiv_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [cdiv_pkg::InW-1:0] a,
  input  logic signed [cdiv_pkg::InW-1:0] b,
  input  logic signed [cdiv_pkg::InW-1:0] c,
  input  logic signed [cdiv_pkg::InW-1:0] d,
  output logic                          out_valid,
  output cdiv_pkg::front_t              out_item
);
  logic              v1, v2, v3;
  logic signed [31:0] ac, bd, bc, ad, cc, dd;
  logic signed [32:0] num_re, num_im;
  logic        [31:0] den2, den3;
  logic        [31:0] mag_re, mag_im;
  logic               neg_re, neg_im, zero3;
  logic        [32:0] t_re, t_im;

  assign t_re = -num_re;
  assign t_im = -num_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac <= a * c;
      bd <= b * d;
      bc <= b * c;
      ad <= a * d;
      cc <= c * c;
      dd <= d * d;
      num_re <= {ac[31], ac} + {bd[31], bd};
      num_im <= {bc[31], bc} - {ad[31], ad};
      den2   <= 32'(cc) + 32'(dd);
      neg_re <= num_re[32];
      neg_im <= num_im[32];
      mag_re <= num_re[32] ? t_re[31:0] : num_re[31:0];
      mag_im <= num_im[32] ? t_im[31:0] : num_im[31:0];
      den3   <= den2;
      zero3  <= den2 == 32'd0;
      out_item.n_re   <= {mag_re, 13'd0} + 45'(den3);
      out_item.n_im   <= {mag_im, 13'd0} + 45'(den3);
      out_item.neg_re <= neg_re;
      out_item.neg_im <= neg_im;
      out_item.dvs    <= {den3, 1'b0};
      out_item.zero   <= zero3;
    end
  end
endmodule

// File: sv/cdiv_divider.sv
// one quotient bit per stage restoring divider, two lanes side by side
// depends on cdiv_pkg
module cdiv_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  cdiv_pkg::front_t     in_item,
  output logic                 out_valid,
  output cdiv_pkg::div_item_t  out_item
);
  localparam int Stages = cdiv_pkg::QuoW;

  cdiv_pkg::div_item_t stg [0:Stages];
  logic [Stages:0]     vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0].re   <= cdiv_pkg::div_init(in_item.n_re, in_item.neg_re, in_item.dvs);
      stg[0].im   <= cdiv_pkg::div_init(in_item.n_im, in_item.neg_im, in_item.dvs);
      stg[0].dvs  <= in_item.dvs;
      stg[0].zero <= in_item.zero;
    end
  end

  for (genvar k = 1; k <= Stages; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        stg[k].re   <= cdiv_pkg::div_step(stg[k-1].re, stg[k-1].dvs);
        stg[k].im   <= cdiv_pkg::div_step(stg[k-1].im, stg[k-1].dvs);
        stg[k].dvs  <= stg[k-1].dvs;
        stg[k].zero <= stg[k-1].zero;
      end
    end
  end

  assign out_valid = vld[Stages];
  assign out_item  = stg[Stages];
endmodule

// File: sv/cdiv_back.sv
// sign, saturation, status and the output register
// depends on cdiv_pkg
module cdiv_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  cdiv_pkg::div_item_t               in_item,
  output logic                              out_valid,
  output logic [cdiv_pkg::OutW-1:0]         q_re,
  output logic [cdiv_pkg::OutW-1:0]         q_im,
  output cdiv_pkg::status_t                 status
);
  localparam logic [cdiv_pkg::QuoW-1:0] LimNeg = cdiv_pkg::QuoW'(1) << (cdiv_pkg::OutW - 1);
  localparam logic [cdiv_pkg::QuoW-1:0] LimPos = LimNeg - cdiv_pkg::QuoW'(1);

  logic [cdiv_pkg::OutW-1:0] r_re, r_im;
  logic                      s_re, s_im;

  function automatic logic [cdiv_pkg::OutW:0] fin(cdiv_pkg::lane_t l);
    logic                       sat;
    logic [cdiv_pkg::OutW-1:0]  v;
    sat = l.ovf || (l.neg ? (l.quo > LimNeg) : (l.quo > LimPos));
    if (sat) begin
      v = l.neg ? LimNeg[cdiv_pkg::OutW-1:0] : LimPos[cdiv_pkg::OutW-1:0];
    end else begin
      v = l.quo[cdiv_pkg::OutW-1:0];
    end
    if (l.neg) begin
      v = -v;
    end
    return {sat, v};
  endfunction

  always_comb begin
    {s_re, r_re} = fin(in_item.re);
    {s_im, r_im} = fin(in_item.im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_item.zero) begin
        q_re   <= '0;
        q_im   <= '0;
        status <= cdiv_pkg::STATUS_ZERO;
      end else begin
        q_re   <= r_re;
        q_im   <= r_im;
        status <= (s_re || s_im) ? cdiv_pkg::STATUS_SAT : cdiv_pkg::STATUS_OK;
      end
    end
  end
endmodule

// File: sv/complex_number_divider.sv
// complex quotient (a+bj)/(c+dj), Q4.12 operands to saturated Q12.12 result
// depends on cdiv_pkg, cdiv_if, cdiv_front, cdiv_divider, cdiv_back
//
//   channel  role    payload
//   req      sink    dividend_re, dividend_im, divisor_re, divisor_im
//   rsp      source  quotient_re, quotient_im, status
//
// one transfer per cycle on each side while rsp does not stall: products
// and scaling first, then one-bit-per-stage restoring division (25 quotient
// bits), then saturation into the output register.
// rst clears only the valid bits. a stall on rsp freezes the whole pipeline,
// empty slots included, and req.ready follows it.
module complex_number_divider (
  input logic       clk,
  input logic       rst,
  cdiv_req_if.sink  req,
  cdiv_rsp_if.source rsp
);
  logic                 en;
  logic                 f_valid, d_valid;
  cdiv_pkg::front_t     f_item;
  cdiv_pkg::div_item_t  d_item;
  cdiv_pkg::status_t    st;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;
  assign rsp.status = st;

  cdiv_front u_front (
    .clk, .rst, .en,
    .in_valid  (req.valid),
    .a         (req.dividend_re),
    .b         (req.dividend_im),
    .c         (req.divisor_re),
    .d         (req.divisor_im),
    .out_valid (f_valid),
    .out_item  (f_item)
  );

  cdiv_divider u_div (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .in_item   (f_item),
    .out_valid (d_valid),
    .out_item  (d_item)
  );

  cdiv_back u_back (
    .clk, .rst, .en,
    .in_valid  (d_valid),
    .in_item   (d_item),
    .out_valid (rsp.valid),
    .q_re      (rsp.quotient_re),
    .q_im      (rsp.quotient_im),
    .status    (st)
  );
endmodule

// File: dv/cdiv_tb_if.sv
`timescale 1ns / 100ps
// testbench view of the operand and quotient channels
// the channel interfaces themselves come from sv/cdiv_if.sv; this file adds none
// depends on cdiv_pkg
package cdiv_tb_types;
  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
  } operands_t;

  typedef struct packed {
    logic signed [23:0] re;
    logic signed [23:0] im;
    cdiv_pkg::status_t  st;
  } quotient_t;
endpackage

// File: dv/testbench.sv
`timescale 1ns / 100ps
// checks complex_number_divider against a bit-accurate quotient predictor
// directed and random operands with random idling on both channels and a long output stall
// depends on cdiv_pkg, cdiv_if, cdiv_tb_types and the divider rtl
module testbench;

  localparam int WatchdogLimit = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_off = 1'b0;
  logic idle_enable = 1'b1;
  logic sending_done = 1'b0;
  logic req_taken = 1'b0;
  int   errors = 0;
  int   quiet_cycles = 0;

  cdiv_tb_types::operands_t pending_operands[$];
  cdiv_tb_types::quotient_t expected_quotients[$];

  cdiv_req_if req ();
  cdiv_rsp_if rsp ();

  complex_number_divider DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #1 clk = ~clk;

  function automatic logic signed [23:0] divide_rounded(longint num, longint den,
                                                        inout logic sat);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 8192 + den) / (den * 2);
    if (num < 0) begin
      if (q > 64'sd8388608) begin
        q = 8388608;
        sat = 1'b1;
      end
      return 24'(-q);
    end
    if (q > 64'sd8388607) begin
      q = 8388607;
      sat = 1'b1;
    end
    return 24'(q);
  endfunction

  function automatic cdiv_tb_types::quotient_t complex_quotient(cdiv_tb_types::operands_t op);
    longint                   a, b, c, d, den;
    logic                     sat;
    cdiv_tb_types::quotient_t r;
    a = op.a;
    b = op.b;
    c = op.c;
    d = op.d;
    den = c * c + d * d;
    sat = 1'b0;
    if (den == 0) begin
      r.re = '0;
      r.im = '0;
      r.st = cdiv_pkg::STATUS_ZERO;
      return r;
    end
    r.re = divide_rounded(a * c + b * d, den, sat);
    r.im = divide_rounded(b * c - a * d, den, sat);
    r.st = sat ? cdiv_pkg::STATUS_SAT : cdiv_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic logic [15:0] random_part();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 15)) - 8);
      4, 5: return 16'(int'($urandom_range(0, 8191)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_operands(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                logic [15:0] d);
    cdiv_tb_types::operands_t op;
    op.a = a;
    op.b = b;
    op.c = c;
    op.d = d;
    pending_operands.push_back(op);
  endtask

  initial begin
    cdiv_tb_types::operands_t op;
    // extremes, zero divisor, saturation, all four quadrants
    queue_operands(16'h1000, 16'h0000, 16'h1000, 16'h0000);
    queue_operands(16'h1000, 16'h1000, 16'h0000, 16'h0000);
    queue_operands(16'h8000, 16'h8000, 16'h0000, 16'h0000);
    queue_operands(16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    queue_operands(16'h8000, 16'h8000, 16'h0001, 16'h0000);
    queue_operands(16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    queue_operands(16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    queue_operands(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_operands(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
    queue_operands(16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
    queue_operands(16'h1000, 16'h2000, 16'h0800, 16'h0800);
    queue_operands(16'h1000, 16'h2000, 16'hf800, 16'h0800);
    queue_operands(16'h1000, 16'h2000, 16'hf800, 16'hf800);
    queue_operands(16'h1000, 16'h2000, 16'h0800, 16'hf800);
    queue_operands(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    queue_operands(16'h0001, 16'h0000, 16'h0003, 16'h0000);
    queue_operands(16'h0001, 16'hffff, 16'h0002, 16'h0000);
    queue_operands(16'h0000, 16'h0001, 16'h0000, 16'h2000);
    queue_operands(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
    for (int i = 0; i < 1230; i++) begin
      op.a = random_part();
      op.b = random_part();
      op.c = random_part();
      op.d = random_part();
      pending_operands.push_back(op);
    end
  end

  // reset, then a long stall on the output and a stretch with no idling
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (pending_operands.size() < 1100);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (200) @(negedge clk);
    hold_off <= 1'b0;
    wait (pending_operands.size() < 700);
    @(negedge clk);
    idle_enable <= 1'b0;
    wait (pending_operands.size() < 400);
    @(negedge clk);
    idle_enable <= 1'b1;
  end

  // transfer seen at the last rising edge
  always @(posedge clk) begin
    req_taken <= !rst && req.valid && req.ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.dividend_re <= '0;
      req.dividend_im <= '0;
      req.divisor_re <= '0;
      req.divisor_im <= '0;
    end else if (!req.valid || req_taken) begin
      if (pending_operands.size() != 0 && !(idle_enable && $urandom_range(0, 99) < 26)) begin
        req.valid <= 1'b1;
        req.dividend_re <= pending_operands[0].a;
        req.dividend_im <= pending_operands[0].b;
        req.divisor_re <= pending_operands[0].c;
        req.divisor_im <= pending_operands[0].d;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !hold_off && !(idle_enable && $urandom_range(0, 99) < 26);
    end
  end

  // monitor
  always @(posedge clk) begin
    cdiv_tb_types::quotient_t want;
    if (!rst) begin
      if (req.valid && req.ready) begin
        cdiv_tb_types::operands_t op;
        op = pending_operands.pop_front();
        expected_quotients.push_back(complex_quotient(op));
        if (pending_operands.size() == 0) begin
          sending_done <= 1'b1;
        end
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_quotients.size() == 0) begin
          $display("%0t: unexpected transfer re=%0d im=%0d status=%0d", $time,
                   rsp.quotient_re, rsp.quotient_im, rsp.status);
          errors++;
        end else begin
          want = expected_quotients.pop_front();
          if (rsp.quotient_re !== want.re) begin
            $display("%0t: quotient_re expected %0d actual %0d", $time, want.re,
                     rsp.quotient_re);
            errors++;
          end
          if (rsp.quotient_im !== want.im) begin
            $display("%0t: quotient_im expected %0d actual %0d", $time, want.im,
                     rsp.quotient_im);
            errors++;
          end
          if (rsp.status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, rsp.status);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (sending_done);
    wait (expected_quotients.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_quotients.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// File: files.f
sv/cdiv_pkg.sv
sv/cdiv_if.sv
sv/cdiv_front.sv
sv/cdiv_divider.sv
sv/cdiv_back.sv
sv/complex_number_divider.sv
dv/cdiv_tb_if.sv
dv/testbench.sv
